// File: rtl/priority_process_scheduler_top_assert.svh
// assertion macros for the scheduler rtl
`ifndef PRIORITY_PROCESS_SCHEDULER_TOP_ASSERT_SVH
`define PRIORITY_PROCESS_SCHEDULER_TOP_ASSERT_SVH

// checked on every edge outside reset
`define PPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define PPS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/pps_pkg.sv
package pps_pkg;

  localparam int PRIO_BITS = 8;
  localparam int TIME_BITS = 16;

  // request codes
  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_TICK    = 2'd1,
    REQ_EXTRACT = 2'd2,
    REQ_NOP     = 2'd3
  } req_t;

  // per-cell command
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2,
    OP_DEC    = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [PRIO_BITS-1:0] priority_req;
    logic [TIME_BITS-1:0] burst_time;
  } in_item_t;

  typedef struct packed {
    logic [PRIO_BITS-1:0] served_priority;
    logic [TIME_BITS-1:0] remaining_time;
    logic                 finished;
    logic                 idle;
    logic                 dropped;
  } out_item_t;

  typedef struct packed {
    logic                 valid;
    logic [PRIO_BITS-1:0] prio;
    logic [TIME_BITS-1:0] run_time;
  } entry_t;

  typedef struct packed {
    cell_op_t             op;
    logic [PRIO_BITS-1:0] prio;
    logic [TIME_BITS-1:0] run_time;
  } cell_cmd_t;

endpackage

// File: rtl/pps_cell.sv
module pps_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  pps_pkg::cell_cmd_t cmd,
  input  pps_pkg::entry_t   left_ent,
  input  logic              left_before,
  input  pps_pkg::entry_t   right_ent,
  output pps_pkg::entry_t   ent,
  output logic              ahead
);

  logic                          valid_r, valid_nxt;
  logic [pps_pkg::PRIO_BITS-1:0] prio_r, prio_nxt;
  logic [pps_pkg::TIME_BITS-1:0] time_r, time_nxt;

  // new item belongs at or ahead of this cell
  assign ahead = !valid_r || (prio_r > cmd.prio);

  assign ent.valid    = valid_r;
  assign ent.prio     = prio_r;
  assign ent.run_time = time_r;

  // next contents of the cell
  always_comb begin
    valid_nxt = valid_r;
    prio_nxt  = prio_r;
    time_nxt  = time_r;
    case (cmd.op)
      pps_pkg::OP_INSERT: begin
        if (left_before) begin
          valid_nxt = left_ent.valid;
          prio_nxt  = left_ent.prio;
          time_nxt  = left_ent.run_time;
        end else if (ahead) begin
          valid_nxt = 1'b1;
          prio_nxt  = cmd.prio;
          time_nxt  = cmd.run_time;
        end
      end
      pps_pkg::OP_POP: begin
        valid_nxt = right_ent.valid;
        prio_nxt  = right_ent.prio;
        time_nxt  = right_ent.run_time;
      end
      pps_pkg::OP_DEC: begin
        time_nxt = time_r - pps_pkg::TIME_BITS'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    time_r <= time_nxt;
  end

endmodule

// File: rtl/priority_process_scheduler_top.sv
// channel | ports                          | direction
// request | in_valid, in_stall, in_data    | in
// result  | out_valid, out_stall, out_data | out
//
// one request per cycle while in_stall is low: every cell compares the new
// priority and moves its entry in the same cycle, and the result beat is registered
// reset clears the valid bit of every cell and the result valid bit
// in_stall is high while a result beat waits and out_stall is high

module priority_process_scheduler_top #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pps_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pps_pkg::out_item_t out_data
);

  localparam int TB = pps_pkg::TIME_BITS;

  pps_pkg::entry_t    ent [0:DEPTH];
  logic               bef [0:DEPTH];
  pps_pkg::cell_cmd_t cmd_all, cmd_head;
  pps_pkg::out_item_t res;
  pps_pkg::out_item_t out_data_r, out_data_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               accept, full, empty;

  assign ent[DEPTH] = '0;
  assign bef[0]     = 1'b0;
  assign full       = ent[DEPTH-1].valid;
  assign empty      = !ent[0].valid;

  // handshake
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // decode request into cell commands and a result
  always_comb begin
    cmd_all.op       = pps_pkg::OP_HOLD;
    cmd_all.prio     = in_data.priority_req;
    cmd_all.run_time = in_data.burst_time;
    cmd_head         = cmd_all;
    res              = '0;
    if (accept) begin
      case (in_data.req_type)
        pps_pkg::REQ_INSERT: begin
          if (full) begin
            res.dropped = 1'b1;
          end else begin
            cmd_all.op  = pps_pkg::OP_INSERT;
            cmd_head.op = pps_pkg::OP_INSERT;
          end
        end
        pps_pkg::REQ_TICK, pps_pkg::REQ_EXTRACT: begin
          if (empty) begin
            res.idle = 1'b1;
          end else begin
            res.served_priority = ent[0].prio;
            if (in_data.req_type == pps_pkg::REQ_TICK && ent[0].run_time > TB'(1)) begin
              cmd_head.op        = pps_pkg::OP_DEC;
              res.remaining_time = ent[0].run_time - TB'(1);
            end else begin
              cmd_all.op   = pps_pkg::OP_POP;
              cmd_head.op  = pps_pkg::OP_POP;
              res.finished = 1'b1;
              if (in_data.req_type == pps_pkg::REQ_EXTRACT) begin
                res.remaining_time = ent[0].run_time;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // chain of cells, head at index zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      pps_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_head),
        .left_ent    ('0),
        .left_before (bef[0]),
        .right_ent   (ent[1]),
        .ent         (ent[0]),
        .ahead       (bef[1])
      );
    end else begin : g_body
      pps_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_all),
        .left_ent    (ent[i-1]),
        .left_before (bef[i]),
        .right_ent   (ent[i+1]),
        .ent         (ent[i]),
        .ahead       (bef[i+1])
      );
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // store invariants: valid entries form a sorted prefix
  logic prefix_ok, sorted_ok;
  always_comb begin
    prefix_ok = 1'b1;
    sorted_ok = 1'b1;
    for (int k = 0; k < DEPTH - 1; k++) begin
      if (ent[k+1].valid && !ent[k].valid) prefix_ok = 1'b0;
      if (ent[k+1].valid && ent[k].valid && ent[k].prio > ent[k+1].prio) sorted_ok = 1'b0;
    end
  end

`include "priority_process_scheduler_top_assert.svh"

  `PPS_ASSERT(a_prefix, prefix_ok, "valid entries are not a prefix")
  `PPS_ASSERT(a_sorted, sorted_ok, "store is not sorted by priority")
  `PPS_ASSERT(a_drop_full, (out_valid_r && out_data_r.dropped) |-> $past(full), "drop without full store")
  `PPS_ASSERT(a_flags, out_valid_r |-> !(out_data_r.finished && (out_data_r.idle || out_data_r.dropped)), "conflicting result flags")
  `PPS_ASSERT_ALWAYS(a_rst, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule

// File: sim/tb_priority_process_scheduler_top.sv
`timescale 1ns / 1ps

module tb_priority_process_scheduler_top;

  localparam int SCHED_DEPTH = 16;
  localparam int PHASE_COUNT = 8;
  localparam int PHASE_ITEMS = 106;
  localparam int REPORT_LIMIT = 10;

  // one row of the directed table
  typedef struct {
    pps_pkg::in_item_t  beat;
    bit                 known;
    pps_pkg::out_item_t result;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  pps_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  pps_pkg::out_item_t out_data;

  // scheduler mirror: sorted by priority, ties in arrival order
  logic [pps_pkg::PRIO_BITS-1:0] sched_prio [SCHED_DEPTH];
  logic [pps_pkg::TIME_BITS-1:0] sched_time [SCHED_DEPTH];
  int                            sched_count = 0;

  pps_pkg::out_item_t pending_results [$];
  stim_row_t          directed_rows [$];
  int                 fault_count = 0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 hold_request = 0;

  // per phase: sender idle, receiver stall, share of inserts
  int phase_send_pct [PHASE_COUNT] = '{0, 49, 0, 21, 0, 49, 0, 21};
  int phase_recv_pct [PHASE_COUNT] = '{0, 0, 49, 21, 0, 0, 49, 21};
  int phase_insert_pct [PHASE_COUNT] = '{70, 45, 65, 40, 70, 45, 65, 40};

  priority_process_scheduler_top #(
    .DEPTH(SCHED_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // 20 ns clock
  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  // one scheduler request applied to the mirror
  function automatic pps_pkg::out_item_t schedule_step(input pps_pkg::in_item_t beat);
    pps_pkg::out_item_t res;
    pps_pkg::req_t      req_code;
    int                 pos;
    res = '0;
    req_code = pps_pkg::req_t'(beat.req_type);
    case (req_code)
      pps_pkg::REQ_INSERT: begin
        if (sched_count >= SCHED_DEPTH) begin
          res.dropped = 1'b1;
        end else begin
          pos = 0;
          while (pos < sched_count && sched_prio[pos] <= beat.priority_req) pos++;
          for (int i = sched_count; i > pos; i--) begin
            sched_prio[i] = sched_prio[i-1];
            sched_time[i] = sched_time[i-1];
          end
          sched_prio[pos] = beat.priority_req;
          sched_time[pos] = beat.burst_time;
          sched_count++;
        end
      end
      pps_pkg::REQ_TICK, pps_pkg::REQ_EXTRACT: begin
        if (sched_count == 0) begin
          res.idle = 1'b1;
        end else begin
          res.served_priority = sched_prio[0];
          if (req_code == pps_pkg::REQ_TICK && sched_time[0] > 1) begin
            sched_time[0] = sched_time[0] - 1'b1;
            res.remaining_time = sched_time[0];
          end else begin
            res.remaining_time = (req_code == pps_pkg::REQ_EXTRACT) ? sched_time[0] : '0;
            res.finished = 1'b1;
            for (int i = 0; i < sched_count - 1; i++) begin
              sched_prio[i] = sched_prio[i+1];
              sched_time[i] = sched_time[i+1];
            end
            sched_count--;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic pps_pkg::out_item_t make_result(input int prio, input int rem,
                                                     input bit fin, input bit idl,
                                                     input bit drp);
    pps_pkg::out_item_t res;
    res.served_priority = prio[pps_pkg::PRIO_BITS-1:0];
    res.remaining_time  = rem[pps_pkg::TIME_BITS-1:0];
    res.finished        = fin;
    res.idle            = idl;
    res.dropped         = drp;
    return res;
  endfunction

  function automatic pps_pkg::in_item_t make_request(input pps_pkg::req_t req_code,
                                                     input int prio, input int burst);
    pps_pkg::in_item_t beat;
    beat.req_type     = req_code;
    beat.priority_req = prio[pps_pkg::PRIO_BITS-1:0];
    beat.burst_time   = burst[pps_pkg::TIME_BITS-1:0];
    return beat;
  endfunction

  function automatic void add_row(input pps_pkg::req_t req_code, input int prio,
                                  input int burst, input bit known,
                                  input pps_pkg::out_item_t res);
    stim_row_t row;
    row.beat   = make_request(req_code, prio, burst);
    row.known  = known;
    row.result = res;
    directed_rows.push_back(row);
  endfunction

  // random request, inserts weighted by the phase
  function automatic pps_pkg::in_item_t random_request(input int insert_pct);
    int            pick;
    int            prio;
    int            burst;
    pps_pkg::req_t req_code;
    pick = $urandom_range(99);
    if (pick < 3) req_code = pps_pkg::REQ_NOP;
    else if (pick < 3 + insert_pct) req_code = pps_pkg::REQ_INSERT;
    else if ($urandom_range(99) < 70) req_code = pps_pkg::REQ_TICK;
    else req_code = pps_pkg::REQ_EXTRACT;
    // narrow priorities make ties likely
    case ($urandom_range(3))
      0:       prio = $urandom_range(7);
      3:       prio = $urandom_range(1) ? 255 : 0;
      default: prio = $urandom_range(255);
    endcase
    // mostly short bursts so ticks retire processes
    case ($urandom_range(9))
      0:       burst = 0;
      1:       burst = 1;
      7:       burst = $urandom_range(65535);
      8:       burst = 65535;
      9:       burst = $urandom_range(300);
      default: burst = $urandom_range(2, 6);
    endcase
    return make_request(req_code, prio, burst);
  endfunction

  // offer one beat, wait for acceptance, record what should come back
  task automatic send_request(input pps_pkg::in_item_t beat, input bit known,
                              input pps_pkg::out_item_t typed);
    int                 gap;
    logic [31:0]        junk;
    pps_pkg::out_item_t predicted;
    gap = 0;
    while (send_idle_pct > 0 && gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      junk = $urandom;
      in_valid <= 1'b0;
      in_data <= junk[$bits(pps_pkg::in_item_t)-1:0];
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_stall);
    predicted = schedule_step(beat);
    pending_results.push_back(known ? typed : predicted);
  endtask

  // sender pause until every result is back or the wait limit is reached
  task automatic wait_drained(input int max_cycles);
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && waited < max_cycles) begin
      @(posedge clk);
      waited++;
    end
  endtask

  function automatic void check_result(input pps_pkg::out_item_t got);
    pps_pkg::out_item_t want;
    if (pending_results.size() == 0) begin
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
        $display("result beat with nothing pending: prio %0d time %0d fin %0b idle %0b drop %0b",
                 got.served_priority, got.remaining_time, got.finished, got.idle,
                 got.dropped);
      return;
    end
    want = pending_results.pop_front();
    if (got.served_priority !== want.served_priority ||
        got.remaining_time !== want.remaining_time || got.finished !== want.finished ||
        got.idle !== want.idle || got.dropped !== want.dropped) begin
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
        $display("result mismatch (exp/got): prio %0d/%0d time %0d/%0d fin %0b/%0b idle %0b/%0b drop %0b/%0b",
                 want.served_priority, got.served_priority, want.remaining_time,
                 got.remaining_time, want.finished, got.finished, want.idle, got.idle,
                 want.dropped, got.dropped);
    end
  endfunction

  // result side: check accepted beats, drive stall
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && !out_stall) check_result(out_data);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // request side: reset, directed table, random phases, final check
  initial begin
    pps_pkg::out_item_t zero_result;
    zero_result = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store, no-op, extremes and ties
    add_row(pps_pkg::REQ_TICK, 0, 0, 1'b1, make_result(0, 0, 0, 1, 0));
    add_row(pps_pkg::REQ_EXTRACT, 255, 65535, 1'b1, make_result(0, 0, 0, 1, 0));
    add_row(pps_pkg::REQ_NOP, 255, 65535, 1'b1, zero_result);
    add_row(pps_pkg::REQ_INSERT, 255, 65535, 1'b1, zero_result);
    add_row(pps_pkg::REQ_INSERT, 0, 0, 1'b1, zero_result);
    add_row(pps_pkg::REQ_INSERT, 0, 1, 1'b1, zero_result);
    // fill the store
    for (int i = 0; i < SCHED_DEPTH - 3; i++)
      add_row(pps_pkg::REQ_INSERT, (i * 37 + 11) % 256, i + 2, 1'b1, zero_result);
    // insert into a full store is refused
    add_row(pps_pkg::REQ_INSERT, 9, 9, 1'b1, make_result(0, 0, 0, 0, 1));
    // time 0 and time 1 both finish on the first tick, in arrival order
    add_row(pps_pkg::REQ_TICK, 0, 0, 1'b1, make_result(0, 0, 1, 0, 0));
    add_row(pps_pkg::REQ_TICK, 0, 0, 1'b1, make_result(0, 0, 1, 0, 0));
    add_row(pps_pkg::REQ_EXTRACT, 0, 0, 1'b0, zero_result);
    add_row(pps_pkg::REQ_TICK, 0, 0, 1'b0, zero_result);
    add_row(pps_pkg::REQ_NOP, 0, 0, 1'b1, zero_result);

    foreach (directed_rows[i])
      send_request(directed_rows[i].beat, directed_rows[i].known, directed_rows[i].result);
    wait_drained(10000);

    // random phases under different idle patterns
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      send_idle_pct = phase_send_pct[ph];
      recv_stall_pct = phase_recv_pct[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold while requests keep coming
        if (ph == 0 && n == PHASE_ITEMS / 2) hold_request = 60;
        send_request(random_request(phase_insert_pct[ph]), 1'b0, zero_result);
      end
      wait_drained(20000);
    end

    wait_drained(20000);
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      fault_count++;
      $display("%0d results never arrived", pending_results.size());
    end
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: priority_process_scheduler_top.f
+incdir+rtl
rtl/pps_pkg.sv
rtl/pps_cell.sv
rtl/priority_process_scheduler_top.sv
sim/tb_priority_process_scheduler_top.sv
